[hw/rtl/bqn_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad notch filter package
// Shared constants, control word layout and microcode program of the
// transposed direct form II biquad section.
// ----------------------------------------------------------------------------
package bqn_pkg;

    localparam int COEF_W         = 16;
    localparam int DELAY_W        = 40;
    localparam int NUM_COEFS      = 5;
    localparam int COEF_FRAC_BITS = 14;

    // Coefficient select; also the register index on the configuration port.
    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        OPND_X,
        OPND_Y
    } opnd_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_PROD_D1,
        ACC_PROD_D2,
        ACC_SUB_PROD,
        ACC_PROD
    } acc_op_t;

    // Delay one saturates the accumulator, delay two saturates acc - product.
    typedef enum logic [1:0] {
        DLY_HOLD,
        DLY_SAT,
        DLY_CLEAR
    } dly_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_FETCH,
        SEQ_PUSH,
        SEQ_RET
    } seq_op_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_MUL_B0 = 4'd1;
    localparam step_t STEP_ACC_D1 = 4'd2;
    localparam step_t STEP_ROUND  = 4'd3;
    localparam step_t STEP_MUL_A1 = 4'd4;
    localparam step_t STEP_SUB_A1 = 4'd5;
    localparam step_t STEP_WR_D1  = 4'd6;
    localparam step_t STEP_PUSH   = 4'd7;
    localparam step_t STEP_CLR    = 4'd8;

    typedef struct packed {
        seq_op_t   seq;
        logic      mul_en;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        acc_op_t   acc_op;
        logic      y_load;
        dly_op_t   d1_op;
        dly_op_t   d2_op;
        logic      out_push;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(step_t step);
        ctrl_t w;
        w.seq      = SEQ_NEXT;
        w.mul_en   = 1'b0;
        w.coef_sel = COEF_B0;
        w.opnd_sel = OPND_X;
        w.acc_op   = ACC_HOLD;
        w.y_load   = 1'b0;
        w.d1_op    = DLY_HOLD;
        w.d2_op    = DLY_HOLD;
        w.out_push = 1'b0;
        unique case (step)
            STEP_IDLE:
            begin
                w.seq = SEQ_FETCH;
            end
            STEP_MUL_B0:
            begin
                w.mul_en = 1'b1;
            end
            STEP_ACC_D1:
            begin
                w.acc_op   = ACC_PROD_D1;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B1;
            end
            STEP_ROUND:
            begin
                w.y_load = 1'b1;
                w.acc_op = ACC_PROD_D2;
            end
            STEP_MUL_A1:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A1;
                w.opnd_sel = OPND_Y;
            end
            STEP_SUB_A1:
            begin
                w.acc_op   = ACC_SUB_PROD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B2;
            end
            STEP_WR_D1:
            begin
                w.d1_op    = DLY_SAT;
                w.acc_op   = ACC_PROD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A2;
                w.opnd_sel = OPND_Y;
            end
            STEP_PUSH:
            begin
                w.d2_op    = DLY_SAT;
                w.out_push = 1'b1;
                w.seq      = SEQ_PUSH;
            end
            STEP_CLR:
            begin
                w.d1_op = DLY_CLEAR;
                w.d2_op = DLY_CLEAR;
                w.seq   = SEQ_RET;
            end
            default:
            begin
                w.seq = SEQ_RET;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/biquad_notch_filter_top.sv]
// ----------------------------------------------------------------------------
// Biquad notch filter
// Second-order IIR section, transposed direct form II, with Q2.14
// coefficients on an APB-style port and 40-bit Q.14 delay states.
// ----------------------------------------------------------------------------
// A filter transfer runs from acceptance through seven microcode steps to a
// result in the output register, and the next sample is accepted only once the
// program has returned to idle; the steps are paced by the single shared
// coefficient-by-sample multiplier that forms all five products in turn.
// A clear transfer (tuser high) zeroes both delay states and returns nothing. The last
// step holds while a previous result has not been taken on the master side.
// s_tuser carries the command bit; tdata carries samples, zero-padded.
module biquad_notch_filter_top
    import bqn_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // sample_in
    input  logic                                   s_tuser,  // command
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // sample_out
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [4:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W   = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 2;
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] coef_reg [NUM_COEFS];
    logic [2:0]        cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && (cfg_idx < 3'(NUM_COEFS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[COEF_B0] <= 16'sd16384;
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
        end
        else if (cfg_wr)
        begin
            coef_reg[cfg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            COEF_B0: prdata = 32'(coef_reg[COEF_B0]);
            COEF_B1: prdata = 32'(coef_reg[COEF_B1]);
            COEF_B2: prdata = 32'(coef_reg[COEF_B2]);
            COEF_A1: prdata = 32'(coef_reg[COEF_A1]);
            COEF_A2: prdata = 32'(coef_reg[COEF_A2]);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    step_t step_reg;
    step_t step_next;
    ctrl_t ctrl;
    logic  out_free;
    logic  step_go;

    assign ctrl     = ucode_rom(step_reg);
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (ctrl.seq == SEQ_FETCH);

    always_comb
    begin
        unique case (ctrl.seq)
            SEQ_FETCH: step_go = s_tvalid;
            SEQ_PUSH:  step_go = out_free;
            default:   step_go = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.seq)
            SEQ_FETCH: step_next = !s_tvalid ? step_reg : (s_tuser ? STEP_CLR : STEP_MUL_B0);
            SEQ_NEXT:  step_next = step_reg + 4'd1;
            SEQ_PUSH:  step_next = step_go ? STEP_IDLE : step_reg;
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic signed [COEF_W-1:0]       coef_val;
    logic signed [SAMPLE_WIDTH-1:0] opnd_val;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        d1_ext;
    logic signed [ACC_W-1:0]        d2_ext;
    logic signed [ACC_W-1:0]        rnd_sum;
    logic signed [ACC_W-1:0]        rnd_shift;
    logic signed [ACC_W-1:0]        d2_diff;
    logic signed [DELAY_W-1:0]      d1_reg;
    logic signed [DELAY_W-1:0]      d1_next;
    logic signed [DELAY_W-1:0]      d2_reg;
    logic signed [DELAY_W-1:0]      d2_next;
    logic signed [DELAY_W-1:0]      d1_sat;
    logic signed [DELAY_W-1:0]      d2_sat;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [SAMPLE_WIDTH-1:0]        m_data_reg;

    always_comb
    begin
        unique case (ctrl.coef_sel)
            COEF_B0: coef_val = coef_reg[COEF_B0];
            COEF_B1: coef_val = coef_reg[COEF_B1];
            COEF_B2: coef_val = coef_reg[COEF_B2];
            COEF_A1: coef_val = coef_reg[COEF_A1];
            COEF_A2: coef_val = coef_reg[COEF_A2];
            default: coef_val = '0;
        endcase
    end

    assign opnd_val  = (ctrl.opnd_sel == OPND_Y) ? y_reg : x_reg;
    assign prod_next = coef_val * opnd_val;

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign d1_ext   = {{(ACC_W - DELAY_W){d1_reg[DELAY_W-1]}}, d1_reg};
    assign d2_ext   = {{(ACC_W - DELAY_W){d2_reg[DELAY_W-1]}}, d2_reg};

    always_comb
    begin
        unique case (ctrl.acc_op)
            ACC_PROD_D1:  acc_next = prod_ext + d1_ext;
            ACC_PROD_D2:  acc_next = prod_ext + d2_ext;
            ACC_SUB_PROD: acc_next = acc_reg - prod_ext;
            ACC_PROD:     acc_next = prod_ext;
            default:      acc_next = acc_reg;
        endcase
    end

    // Round half up, then saturate to the sample range.
    assign rnd_sum   = acc_reg + $signed(RND_HALF);
    assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

    always_comb
    begin
        if ((&rnd_shift[ACC_W-1:SAMPLE_WIDTH-1]) || !(|rnd_shift[ACC_W-1:SAMPLE_WIDTH-1]))
        begin
            y_next = rnd_shift[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_next = {rnd_shift[ACC_W-1], {(SAMPLE_WIDTH - 1){~rnd_shift[ACC_W-1]}}};
        end
    end

    // Saturate the delay updates to 40 bits.
    assign d2_diff = acc_reg - prod_ext;

    always_comb
    begin
        if ((&acc_reg[ACC_W-1:DELAY_W-1]) || !(|acc_reg[ACC_W-1:DELAY_W-1]))
        begin
            d1_sat = acc_reg[DELAY_W-1:0];
        end
        else
        begin
            d1_sat = {acc_reg[ACC_W-1], {(DELAY_W - 1){~acc_reg[ACC_W-1]}}};
        end
        if ((&d2_diff[ACC_W-1:DELAY_W-1]) || !(|d2_diff[ACC_W-1:DELAY_W-1]))
        begin
            d2_sat = d2_diff[DELAY_W-1:0];
        end
        else
        begin
            d2_sat = {d2_diff[ACC_W-1], {(DELAY_W - 1){~d2_diff[ACC_W-1]}}};
        end
    end

    always_comb
    begin
        unique case (ctrl.d1_op)
            DLY_SAT:   d1_next = d1_sat;
            DLY_CLEAR: d1_next = '0;
            default:   d1_next = d1_reg;
        endcase
        unique case (ctrl.d2_op)
            DLY_SAT:   d2_next = d2_sat;
            DLY_CLEAR: d2_next = '0;
            default:   d2_next = d2_reg;
        endcase
    end

    always_comb
    begin
        if (ctrl.out_push && step_go)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg      <= '0;
            d2_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (step_go)
            begin
                d1_reg <= d1_next;
                d2_reg <= d2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            x_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (step_go)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.y_load)
        begin
            y_reg <= y_next;
        end
        if (ctrl.out_push && step_go)
        begin
            m_data_reg <= y_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (step_reg == STEP_CLR))
        else $error("clear transfer did not branch to the clear step");

    a_filter_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> (step_reg == STEP_MUL_B0))
        else $error("filter transfer did not start the program");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_CLR) |=> (d1_reg == '0 && d2_reg == '0 && step_reg == STEP_IDLE))
        else $error("clear step left delay state or sequencer wrong");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_PUSH && step_go) |=> (m_tvalid && step_reg == STEP_IDLE))
        else $error("result not presented after the last step");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg <= STEP_CLR))
        else $error("step counter left the program");

endmodule
